// ===== rtl/core/bstk_pkg.sv =====
// ----------------------------------------------------------------------------
// bstk_pkg
// Shared types, codes and sizes for the bounded stack with palindrome check.
// ----------------------------------------------------------------------------
package bstk_pkg;

   localparam int DEPTH  = 16;
   localparam int WORD_W = 32;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int FILL_W = 5;

   localparam logic [1:0] OP_PUSH  = 2'd0;
   localparam logic [1:0] OP_POP   = 2'd1;
   localparam logic [1:0] OP_CHECK = 2'd2;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_OVERFLOW  = 2'd1;
   localparam logic [1:0] ST_UNDERFLOW = 2'd2;
   localparam logic [1:0] ST_EMPTY     = 2'd3;

   typedef struct packed {
      logic [1:0]               operation;
      logic signed [WORD_W-1:0] push_value;
   } req_type;

   typedef struct packed {
      logic [1:0]               status;
      logic signed [WORD_W-1:0] popped_value;
      logic                     is_palindrome;
      logic [FILL_W-1:0]        fill_count;
   } rsp_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_POP,
      S_CHECK
   } state_type;

endpackage

// ===== rtl/core/bstk_ram.sv =====
// ----------------------------------------------------------------------------
// bstk_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module bstk_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_a_addr,
   output logic [WIDTH-1:0]                      rd_a_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_b_addr,
   output logic [WIDTH-1:0]                      rd_b_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_a_addr];
      rd_b_ff <= mem_ff[rd_b_addr];
   end

   assign rd_a_data = rd_a_ff;
   assign rd_b_data = rd_b_ff;

endmodule

// ===== rtl/core/bounded_stack_with_palindrome_check.sv =====
// ----------------------------------------------------------------------------
// bounded_stack_with_palindrome_check
// LIFO stack of signed words held in a dual-read RAM, with push, pop and a
// mirror-symmetry check that walks entry pairs from both ends.
// ----------------------------------------------------------------------------
//  channel   ports                      direction  transaction
//  request   start, busy, req_item      in         start high while busy low
//  response  rsp_valid, rsp_item        out        one cycle strobe, no stall
//
//  push, overflow, underflow, empty and single-entry check: result in the cycle
//  after acceptance, busy stays low. pop: one RAM read, then the result register.
//  check of n > 1 entries: one mirrored pair read per cycle
//  on the two RAM read ports.
//  synchronous reset empties the stack; RAM contents are not cleared.
// ----------------------------------------------------------------------------
module bounded_stack_with_palindrome_check
   import bstk_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_valid,
   output rsp_type rsp_item
);

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [ADDR_W-1:0]  lo_ff, lo_in;
   logic [ADDR_W-1:0]  hi_ff, hi_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic [ADDR_W-1:0]  rd_a_addr;
   logic [ADDR_W-1:0]  rd_b_addr;
   logic [WORD_W-1:0]  rd_a_data;
   logic [WORD_W-1:0]  rd_b_data;

   logic [CNT_W-1:0]   cnt_inc;
   logic [CNT_W-1:0]   cnt_dec;
   logic [ADDR_W-1:0]  top_addr;
   logic [ADDR_W-1:0]  pair_gap;
   logic               is_full;
   logic               is_empty;
   logic               pair_last;
   logic               pair_diff;

   bstk_ram #(
      .WIDTH(WORD_W),
      .DEPTH(DEPTH)
   ) u_ram (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (req_item.push_value),
      .rd_a_addr(rd_a_addr),
      .rd_a_data(rd_a_data),
      .rd_b_addr(rd_b_addr),
      .rd_b_data(rd_b_data)
   );

   assign cnt_inc   = count_ff + CNT_W'(1);
   assign cnt_dec   = count_ff - CNT_W'(1);
   assign top_addr  = cnt_dec[ADDR_W-1:0];
   assign is_full   = (count_ff == CNT_W'(DEPTH));
   assign is_empty  = (count_ff == '0);
   // hi is always above lo while a check runs
   assign pair_gap  = hi_ff - lo_ff;
   assign pair_last = ({1'b0, pair_gap} <= (ADDR_W + 1)'(2));
   assign pair_diff = (rd_a_data != rd_b_data);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (req_item.operation == OP_POP && !is_empty) begin
                  state_in = S_POP;
               end else if (req_item.operation == OP_CHECK &&
                            count_ff > CNT_W'(1)) begin
                  state_in = S_CHECK;
               end
            end
         end
         S_POP: begin
            state_in = S_IDLE;
         end
         S_CHECK: begin
            if (pair_diff || pair_last) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // datapath and memory control
   always_comb begin
      wr_en        = 1'b0;
      wr_addr      = count_ff[ADDR_W-1:0];
      rd_a_addr    = '0;
      rd_b_addr    = top_addr;
      count_in     = count_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      rsp_in.status     = ST_OK;
      rsp_in.fill_count = FILL_W'(count_ff);
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               case (req_item.operation)
                  OP_PUSH: begin
                     rsp_valid_in = 1'b1;
                     if (is_full) begin
                        rsp_in.status = ST_OVERFLOW;
                     end else begin
                        wr_en             = 1'b1;
                        count_in          = cnt_inc;
                        rsp_in.fill_count = FILL_W'(cnt_inc);
                     end
                  end
                  OP_POP: begin
                     if (is_empty) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = ST_UNDERFLOW;
                     end else begin
                        count_in = cnt_dec;
                     end
                  end
                  OP_CHECK: begin
                     if (is_empty) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = ST_EMPTY;
                     end else if (count_ff == CNT_W'(1)) begin
                        rsp_valid_in         = 1'b1;
                        rsp_in.is_palindrome = 1'b1;
                     end else begin
                        lo_in = '0;
                        hi_in = top_addr;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_POP: begin
            // count already dropped when the read was issued
            rsp_valid_in        = 1'b1;
            rsp_in.popped_value = rd_b_data;
         end
         S_CHECK: begin
            rd_a_addr = lo_ff + ADDR_W'(1);
            rd_b_addr = hi_ff - ADDR_W'(1);
            lo_in     = rd_a_addr;
            hi_in     = rd_b_addr;
            if (pair_diff) begin
               rsp_valid_in = 1'b1;
            end else if (pair_last) begin
               rsp_valid_in         = 1'b1;
               rsp_in.is_palindrome = 1'b1;
            end
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      rsp_ff <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

// ===== rtl/core/bstk_checker.sv =====
// ----------------------------------------------------------------------------
// bstk_checker
// Port-level checks on the stack: results follow transactions, and result
// fields stay consistent with the reported status.
// ----------------------------------------------------------------------------
module bstk_checker
   import bstk_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_valid,
   input rsp_type rsp_item
);

   // every accepted transaction answers at once or keeps the block busy
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (rsp_valid || busy))
      else $error("accepted transaction neither answered nor in progress");

   // a long operation ends with its result
   a_busy_end_result: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("busy dropped without a result");

   a_no_result_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while still busy");

   a_error_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_item.status == ST_OK) ||
                     (rsp_item.popped_value == '0 && !rsp_item.is_palindrome)))
      else $error("error result carries data");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((DEPTH > 31) || (32'(rsp_item.fill_count) <= DEPTH)))
      else $error("fill count beyond depth");

endmodule

bind bounded_stack_with_palindrome_check bstk_checker u_bstk_checker (.*);

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bounded stack with palindrome check. A short
// table of directed operations covers empty, single-entry and full stacks,
// then random sequences build mirrored contents, noise and fill/drain runs.
// Typed rows check the table, the rest a shadow stack updated at acceptance.
// ----------------------------------------------------------------------------
module tb_top;
   import bstk_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int MAX_SHOWN    = 10;
   localparam int RANDOM_ITEMS = 750;
   localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7fff_ffff;
   localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;

   typedef struct {
      logic [1:0]               operation;
      logic signed [WORD_W-1:0] push_value;
      int                       reps;
      bit                       typed;
      rsp_type                  result;
   } stim_row_type;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_item;
   logic    rsp_valid;
   rsp_type rsp_item;

   stim_row_type             stim_table[$];
   rsp_type                  expected_results[$];
   logic signed [WORD_W-1:0] shadow_words [DEPTH];
   int                       shadow_fill;
   int                       accepted_count;
   int                       mismatch_count;
   int                       items_sent;
   bit                       typed_on;
   rsp_type                  typed_rsp;
   bit                       no_idle;

   bounded_stack_with_palindrome_check dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("FAILURE");
      $finish;
   end

   // shadow stack, updated once per accepted transaction
   function automatic rsp_type stack_predict(req_type r);
      rsp_type res;
      res = '0;
      case (r.operation)
         OP_PUSH: begin
            if (shadow_fill >= DEPTH) begin
               res.status = ST_OVERFLOW;
            end else begin
               shadow_words[shadow_fill] = r.push_value;
               shadow_fill++;
            end
         end
         OP_POP: begin
            if (shadow_fill == 0) begin
               res.status = ST_UNDERFLOW;
            end else begin
               shadow_fill--;
               res.popped_value = shadow_words[shadow_fill];
            end
         end
         OP_CHECK: begin
            if (shadow_fill == 0) begin
               res.status = ST_EMPTY;
            end else begin
               res.is_palindrome = 1'b1;
               for (int i = 0; i < shadow_fill / 2; i++) begin
                  if (shadow_words[i] != shadow_words[shadow_fill - 1 - i])
                     res.is_palindrome = 1'b0;
               end
            end
         end
         default: ;
      endcase
      res.fill_count = shadow_fill[FILL_W-1:0];
      return res;
   endfunction

   task automatic note_mismatch(string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_SHOWN)
         $display("mismatch at %0t: %s", $realtime, msg);
   endtask

   always @(posedge clock) begin : monitor
      rsp_type want;
      if (!reset) begin
         if (rsp_valid === 1'b1) begin
            if (expected_results.size() == 0) begin
               note_mismatch($sformatf("unexpected transaction %h", rsp_item));
            end else begin
               want = expected_results.pop_front();
               if (rsp_item.status !== want.status)
                  note_mismatch($sformatf("status exp %0d got %0d",
                                          want.status, rsp_item.status));
               if (rsp_item.popped_value !== want.popped_value)
                  note_mismatch($sformatf("popped_value exp %h got %h",
                                          want.popped_value, rsp_item.popped_value));
               if (rsp_item.is_palindrome !== want.is_palindrome)
                  note_mismatch($sformatf("is_palindrome exp %b got %b",
                                          want.is_palindrome, rsp_item.is_palindrome));
               if (rsp_item.fill_count !== want.fill_count)
                  note_mismatch($sformatf("fill_count exp %0d got %0d",
                                          want.fill_count, rsp_item.fill_count));
            end
         end
         if (start && !busy) begin
            want = stack_predict(req_item);
            if (typed_on)
               want = typed_rsp;
            expected_results.push_back(want);
            accepted_count++;
         end
      end
   end

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_item(logic [1:0] op, logic signed [WORD_W-1:0] value,
                            bit typed, rsp_type result);
      int      gap;
      int      seen;
      req_type r;
      gap = no_idle ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      r.operation  = op;
      r.push_value = value;
      typed_on     = typed;
      typed_rsp    = result;
      start       <= 1'b1;
      req_item    <= r;
      seen = accepted_count;
      do @(negedge clock); while (accepted_count == seen);
      typed_on = 1'b0;
      items_sent++;
   endtask

   task automatic send_plain(logic [1:0] op, logic signed [WORD_W-1:0] value);
      send_item(op, value, 1'b0, '0);
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      do @(negedge clock); while (expected_results.size() > 0);
   endtask

   task automatic add_row(logic [1:0] op, logic signed [WORD_W-1:0] value, int reps,
                          bit typed, logic [1:0] st, logic signed [WORD_W-1:0] popped,
                          logic pal, int fill);
      stim_row_type row;
      row.operation                  = op;
      row.push_value                 = value;
      row.reps                       = reps;
      row.typed                      = typed;
      row.result.status              = st;
      row.result.popped_value        = popped;
      row.result.is_palindrome       = pal;
      row.result.fill_count          = fill[FILL_W-1:0];
      stim_table.push_back(row);
   endtask

   // narrow words make accidental mirror matches likely
   function automatic logic signed [WORD_W-1:0] pick_word(bit narrow);
      case ($urandom_range(0, 7))
         0: return WORD_MAX;
         1: return WORD_MIN;
         2: return '0;
         3: return '1;
         default: return narrow ? $urandom_range(0, 3) : $urandom();
      endcase
   endfunction

   task automatic run_mirror_build();
      logic signed [WORD_W-1:0] vals [DEPTH];
      int len;
      int flip;
      while (shadow_fill > 0)
         send_plain(OP_POP, pick_word(1'b0));
      len = ($urandom_range(0, 4) == 0) ? DEPTH : $urandom_range(1, DEPTH);
      for (int i = 0; i < (len + 1) / 2; i++) begin
         vals[i]           = pick_word(1'b0);
         vals[len - 1 - i] = vals[i];
      end
      // flip one bit at a random place now and then, breaking the symmetry unless it hits the middle entry
      if (len > 1 && $urandom_range(0, 2) == 0) begin
         flip = $urandom_range(0, len - 1);
         vals[flip] = vals[flip] ^ (32'sd1 <<< $urandom_range(0, WORD_W - 1));
      end
      for (int i = 0; i < len; i++) begin
         send_plain(OP_PUSH, vals[i]);
         if ($urandom_range(0, 5) == 0)
            send_plain(OP_CHECK, pick_word(1'b0));
      end
      send_plain(OP_CHECK, pick_word(1'b0));
      if ($urandom_range(0, 1) == 0) begin
         send_plain(OP_POP, pick_word(1'b0));
         send_plain(OP_CHECK, pick_word(1'b0));
      end
   endtask

   task automatic run_noise();
      int count;
      count = $urandom_range(20, 40);
      repeat (count) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: send_plain(OP_PUSH, pick_word(1'b1));
            5, 6, 7:       send_plain(OP_POP, pick_word(1'b0));
            8:             send_plain(OP_CHECK, pick_word(1'b0));
            default:       send_plain(OP_UNUSED, pick_word(1'b0));
         endcase
      end
   endtask

   task automatic run_fill_drain();
      while (shadow_fill < DEPTH)
         send_plain(OP_PUSH, pick_word(1'b1));
      repeat ($urandom_range(1, 2)) send_plain(OP_PUSH, pick_word(1'b0));
      send_plain(OP_CHECK, pick_word(1'b0));
      while (shadow_fill > 0)
         send_plain(OP_POP, pick_word(1'b0));
      send_plain(OP_POP, pick_word(1'b0));
      send_plain(OP_CHECK, pick_word(1'b0));
   endtask

   initial begin
      reset          = 1'b1;
      start          = 1'b0;
      req_item       = '0;
      typed_on       = 1'b0;
      typed_rsp      = '0;
      no_idle        = 1'b0;
      shadow_fill    = 0;
      accepted_count = 0;
      mismatch_count = 0;
      items_sent     = 0;

      add_row(OP_POP,    32'sd0,   1, 1'b1, ST_UNDERFLOW, 32'sd0,   1'b0, 0);
      add_row(OP_CHECK,  32'sd0,   1, 1'b1, ST_EMPTY,     32'sd0,   1'b0, 0);
      add_row(OP_UNUSED, '1,       1, 1'b1, ST_OK,        32'sd0,   1'b0, 0);
      add_row(OP_PUSH,   WORD_MAX, 1, 1'b1, ST_OK,        32'sd0,   1'b0, 1);
      add_row(OP_CHECK,  32'sd0,   1, 1'b1, ST_OK,        32'sd0,   1'b1, 1);
      add_row(OP_PUSH,   WORD_MIN, 1, 1'b1, ST_OK,        32'sd0,   1'b0, 2);
      add_row(OP_CHECK,  '1,       1, 1'b1, ST_OK,        32'sd0,   1'b0, 2);
      add_row(OP_POP,    32'sd0,   1, 1'b1, ST_OK,        WORD_MIN, 1'b0, 1);
      add_row(OP_UNUSED, WORD_MIN, 1, 1'b1, ST_OK,        32'sd0,   1'b0, 1);
      add_row(OP_PUSH,   WORD_MIN, DEPTH - 2, 1'b0, ST_OK, 32'sd0,  1'b0, 0);
      add_row(OP_PUSH,   WORD_MAX, 1, 1'b1, ST_OK,        32'sd0,   1'b0, DEPTH);
      add_row(OP_CHECK,  32'sd0,   1, 1'b1, ST_OK,        32'sd0,   1'b1, DEPTH);
      add_row(OP_PUSH,   32'sd0,   1, 1'b1, ST_OVERFLOW,  32'sd0,   1'b0, DEPTH);
      add_row(OP_POP,    32'sd0,   1, 1'b1, ST_OK,        WORD_MAX, 1'b0, DEPTH - 1);
      add_row(OP_CHECK,  32'sd0,   1, 1'b0, ST_OK,        32'sd0,   1'b0, 0);

      repeat (5) @(negedge clock);
      reset <= 1'b0;

      foreach (stim_table[k]) begin
         repeat (stim_table[k].reps)
            send_item(stim_table[k].operation, stim_table[k].push_value,
                      stim_table[k].typed, stim_table[k].result);
      end
      wait_drained();

      while (items_sent < stim_table.size() + RANDOM_ITEMS) begin
         no_idle = ($urandom_range(0, 3) == 0);
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: run_mirror_build();
            6, 7, 8:          run_noise();
            default:          run_fill_drain();
         endcase
         if ($urandom_range(0, 7) == 0)
            wait_drained();
      end

      wait_drained();
      repeat (4 * DEPTH) @(negedge clock);
      if (mismatch_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
